// ===== design/gbe_pkg.sv =====
// ----------------------------------------------------------------------------
// gbe_pkg
// Shared types, codes and the colour helper for the glyph bitmap expander.
// ----------------------------------------------------------------------------
package gbe_pkg;

    localparam int COORD_BITS_DEF = 14;
    localparam int ADDR_BITS_DEF  = 28;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FB_FORMAT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_EIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH       = 3'd7;

    // framebuffer formats
    localparam logic [1:0] FMT_8BPP   = 2'd0;
    localparam logic [1:0] FMT_RGB565 = 2'd1;
    localparam logic [1:0] FMT_32BPP  = 2'd2;
    localparam logic [1:0] FMT_BAD    = 2'd3;

    // write sizes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    typedef struct packed {
        logic [1:0]  fb_format;
        logic [15:0] line_bytes;
        logic [31:0] fg_color;
        logic [31:0] bg_color;
        logic        glyph_depth_eight;
        logic [27:0] glyph_origin;
        logic [27:0] glyph_extent;
        logic [10:0] glyph_pitch;
    } cfg_t;

    // per source byte control handed from the walker to the emitter
    typedef struct packed {
        logic       err;
        logic       done;
        logic [2:0] last_idx;
        logic [7:0] mask;
    } desc_ctl_t;

    function automatic logic [15:0] to_rgb565(input logic [31:0] c);
        logic [4:0] r;
        logic [5:0] g;
        logic [4:0] b;
        r = c[16+3 +: 5];
        g = c[8+2 +: 6];
        b = c[3 +: 5];
        return {r, g, b};
    endfunction

endpackage

// ===== design/glyph_bitmap_expander.sv =====
// ----------------------------------------------------------------------------
// glyph_bitmap_expander
// Expands glyph source bytes into framebuffer pixel writes.
// ----------------------------------------------------------------------------
// Source bytes go in on the slave stream and pixel writes come out on the
// master stream, one write per cycle while the sink is ready. In 1-bit mode
// the next byte waits until the pixels of the current one inside the glyph
// width, one to eight, have entered the single pixel output register at one
// pixel per ready cycle; in 8-bit mode, and for bytes that give no write, a
// byte is taken every cycle unless earlier pixels still wait. Configuration
// writes restart the glyph and must only be made while the block is idle.
module glyph_bitmap_expander #(
    parameter int COORD_BITS = gbe_pkg::COORD_BITS_DEF,
    parameter int ADDR_BITS  = gbe_pkg::ADDR_BITS_DEF,
    parameter int DATA_W     = ((ADDR_BITS + 34 + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [gbe_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [gbe_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // src_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [DATA_W-1:0]                  m_tdata,   // pixel_address, pixel_data, pixel_size
    output logic                               m_tlast,   // last_of_byte
    output logic [1:0]                         m_tuser    // glyph_done, format_error
);
    import gbe_pkg::*;

    cfg_t                  cfg;
    desc_ctl_t             desc_ctl;
    logic                  clear, desc_ready, desc_push, desc_busy;
    logic [COORD_BITS-1:0] desc_x;
    logic [ADDR_BITS-1:0]  desc_row_base;
    logic [ADDR_BITS-1:0]  pixel_address;
    logic [31:0]           pixel_data;
    logic [1:0]            pixel_size;
    logic                  glyph_done, format_error;

    gbe_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .clear     (clear)
    );

    gbe_walker #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_walker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .clear         (clear),
        .s_tvalid      (s_tvalid),
        .src_byte      (s_tdata),
        .desc_ready    (desc_ready),
        .s_tready      (s_tready),
        .desc_push     (desc_push),
        .desc_ctl      (desc_ctl),
        .desc_x        (desc_x),
        .desc_row_base (desc_row_base)
    );

    gbe_emitter #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .desc_push     (desc_push),
        .desc_ctl      (desc_ctl),
        .desc_x        (desc_x),
        .desc_row_base (desc_row_base),
        .desc_ready    (desc_ready),
        .desc_busy     (desc_busy),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .pixel_address (pixel_address),
        .pixel_data    (pixel_data),
        .pixel_size    (pixel_size),
        .last_of_byte  (m_tlast),
        .glyph_done    (glyph_done),
        .format_error  (format_error)
    );

    assign m_tdata = DATA_W'({pixel_size, pixel_data, pixel_address});
    assign m_tuser = {format_error, glyph_done};

    // an unsupported format ends its byte with one empty write
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && format_error |-> m_tlast && pixel_address == '0 && pixel_data == 32'd0)
        else $error("format error transaction is not a lone empty write");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && glyph_done |-> m_tlast && !format_error)
        else $error("glyph_done away from the last write of a byte");

    // a byte still expanding behind a stalled output holds off new input
    assert property (@(posedge clk) disable iff (!rst_n)
        desc_busy && m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while the pixel run is stalled");

    // every pushed pixel run is taken into the run register and marks it busy
    assert property (@(posedge clk) disable iff (!rst_n)
        desc_push |=> desc_busy)
        else $error("pixel run lost after push");

endmodule

// ===== design/gbe_cfg.sv =====
// ----------------------------------------------------------------------------
// gbe_cfg
// Configuration register file; every write also restarts the glyph.
// ----------------------------------------------------------------------------
module gbe_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [gbe_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [gbe_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output gbe_pkg::cfg_t                      cfg,
    output logic                               clear
);
    import gbe_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        case (cfg_addr)
            REG_FB_FORMAT:   cfg_next.fb_format         = cfg_wdata[1:0];
            REG_LINE_BYTES:  cfg_next.line_bytes        = cfg_wdata[15:0];
            REG_FG_COLOR:    cfg_next.fg_color          = cfg_wdata[31:0];
            REG_BG_COLOR:    cfg_next.bg_color          = cfg_wdata[31:0];
            REG_DEPTH_EIGHT: cfg_next.glyph_depth_eight = cfg_wdata[0];
            REG_ORIGIN:      cfg_next.glyph_origin      = cfg_wdata[27:0];
            REG_EXTENT:      cfg_next.glyph_extent      = cfg_wdata[27:0];
            REG_PITCH:       cfg_next.glyph_pitch       = cfg_wdata[10:0];
            default:         cfg_next = cfg_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // fb_format is the top field of the packed register set
            cfg_reg <= cfg_t'({FMT_32BPP, {($bits(cfg_t)-2){1'b0}}});
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg   = cfg_reg;
    assign clear = cfg_we;

endmodule

// ===== design/gbe_walker.sv =====
// ----------------------------------------------------------------------------
// gbe_walker
// Tracks the glyph position and turns each source byte into a pixel run.
// ----------------------------------------------------------------------------
module gbe_walker #(
    parameter int COORD_BITS = gbe_pkg::COORD_BITS_DEF,
    parameter int ADDR_BITS  = gbe_pkg::ADDR_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gbe_pkg::cfg_t           cfg,
    input  logic                    clear,
    input  logic                    s_tvalid,
    input  logic [7:0]              src_byte,
    input  logic                    desc_ready,
    output logic                    s_tready,
    output logic                    desc_push,
    output gbe_pkg::desc_ctl_t      desc_ctl,
    output logic [COORD_BITS-1:0]   desc_x,
    output logic [ADDR_BITS-1:0]    desc_row_base
);
    import gbe_pkg::*;

    localparam int PROD_W = COORD_BITS + 16;

    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [10:0]           bir_reg, bir_next;
    logic                  finished_reg, finished_next;

    logic [27:0]           ext_hi, org_hi;
    logic [COORD_BITS-1:0] w, h, ox, oy, rem, col_adv, row_inc, y;
    logic [10:0]           pitch_eff, bir_inc;
    logic [3:0]            n_cnt;
    logic [2:0]            last_idx;
    logic [PROD_W-1:0]     prod;
    logic                  accept, in_glyph, produce, err, rem_lt8, rem_le8;
    logic                  row_end, last_row, reaches_end;

    assign ext_hi = cfg.glyph_extent >> COORD_BITS;
    assign org_hi = cfg.glyph_origin >> COORD_BITS;
    assign w      = cfg.glyph_extent[COORD_BITS-1:0];
    assign h      = ext_hi[COORD_BITS-1:0];
    assign ox     = cfg.glyph_origin[COORD_BITS-1:0];
    assign oy     = org_hi[COORD_BITS-1:0];

    assign s_tready = desc_ready;
    assign accept   = s_tvalid && desc_ready;

    assign in_glyph = row_reg < h;
    assign produce  = col_reg < w;
    assign err      = cfg.fb_format == FMT_BAD;
    assign rem      = w - col_reg;
    assign rem_lt8  = rem < COORD_BITS'(8);
    assign rem_le8  = rem <= COORD_BITS'(8);

    always_comb
    begin
        if (!produce)
            n_cnt = 4'd0;
        else if (cfg.glyph_depth_eight)
            n_cnt = 4'd1;
        else if (rem_lt8)
            n_cnt = 4'(rem);
        else
            n_cnt = 4'd8;
    end

    always_comb
    begin
        if (err || cfg.glyph_depth_eight)
            last_idx = 3'd0;
        else if (rem_lt8)
            last_idx = 3'(rem - COORD_BITS'(1));
        else
            last_idx = 3'd7;
    end

    assign col_adv   = col_reg + COORD_BITS'(n_cnt);
    assign row_inc   = row_reg + COORD_BITS'(1);
    assign pitch_eff = (cfg.glyph_pitch == 11'd0) ? 11'd1 : cfg.glyph_pitch;
    assign bir_inc   = bir_reg + 11'd1;
    assign row_end   = cfg.glyph_depth_eight ? (col_adv >= w) : (bir_inc >= pitch_eff);

    // glyph_done lands on the last pixel of the byte that reaches the right edge of the last row
    assign last_row    = row_inc == h;
    assign reaches_end = cfg.glyph_depth_eight ? (rem == COORD_BITS'(1)) : rem_le8;

    assign y    = oy + row_reg;
    assign prod = PROD_W'(y) * PROD_W'(cfg.line_bytes);

    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        bir_next      = bir_reg;
        finished_next = finished_reg;
        if (clear)
        begin
            row_next      = '0;
            col_next      = '0;
            bir_next      = '0;
            finished_next = 1'b0;
        end
        else if (accept && !finished_reg)
        begin
            if (!in_glyph)
            begin
                finished_next = 1'b1;
            end
            else if (produce && err)
            begin
                finished_next = 1'b1;
            end
            else if (row_end)
            begin
                col_next      = '0;
                bir_next      = '0;
                row_next      = row_inc;
                finished_next = row_inc >= h;
            end
            else
            begin
                col_next = col_adv;
                bir_next = cfg.glyph_depth_eight ? bir_reg : bir_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            bir_reg      <= '0;
            finished_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            bir_reg      <= bir_next;
            finished_reg <= finished_next;
        end
    end

    assign desc_push         = accept && !finished_reg && in_glyph && produce;
    assign desc_ctl.err      = err;
    assign desc_ctl.done     = last_row && reaches_end && !err;
    assign desc_ctl.last_idx = last_idx;
    assign desc_ctl.mask     = cfg.glyph_depth_eight ? {8{src_byte != 8'd0}} : src_byte;
    assign desc_x            = ox + col_reg;
    assign desc_row_base     = ADDR_BITS'(prod);

endmodule

// ===== design/gbe_emitter.sv =====
// ----------------------------------------------------------------------------
// gbe_emitter
// Steps through the pixels of one source byte into the pixel write register.
// ----------------------------------------------------------------------------
module gbe_emitter #(
    parameter int COORD_BITS = gbe_pkg::COORD_BITS_DEF,
    parameter int ADDR_BITS  = gbe_pkg::ADDR_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gbe_pkg::cfg_t           cfg,
    input  logic                    desc_push,
    input  gbe_pkg::desc_ctl_t      desc_ctl,
    input  logic [COORD_BITS-1:0]   desc_x,
    input  logic [ADDR_BITS-1:0]    desc_row_base,
    output logic                    desc_ready,
    output logic                    desc_busy,
    input  logic                    m_tready,
    output logic                    m_tvalid,
    output logic [ADDR_BITS-1:0]    pixel_address,
    output logic [31:0]             pixel_data,
    output logic [1:0]              pixel_size,
    output logic                    last_of_byte,
    output logic                    glyph_done,
    output logic                    format_error
);
    import gbe_pkg::*;

    localparam int XS_W = COORD_BITS + 2;

    logic                  dvalid_reg;
    desc_ctl_t             ctl_reg;
    logic [COORD_BITS-1:0] x_reg;
    logic [ADDR_BITS-1:0]  base_reg;
    logic [2:0]            k_reg;

    logic                  ovalid_reg;
    logic [ADDR_BITS-1:0]  addr_reg, addr_next;
    logic [31:0]           data_reg, data_next;
    logic [1:0]            size_reg, size_next;
    logic                  last_reg, last_next;
    logic                  done_reg, done_next;
    logic                  err_reg;

    logic                  out_load, k_last, set;
    logic [31:0]           color;
    logic [COORD_BITS-1:0] px_x;
    logic [XS_W-1:0]       xs;

    assign out_load   = dvalid_reg && (!ovalid_reg || m_tready);
    assign k_last     = k_reg == ctl_reg.last_idx;
    assign desc_ready = !dvalid_reg || (out_load && k_last);
    assign desc_busy  = dvalid_reg;

    // bit 7 of the source byte is the leftmost pixel
    assign set   = ctl_reg.mask[~k_reg];
    assign color = set ? cfg.fg_color : cfg.bg_color;
    assign px_x  = x_reg + COORD_BITS'(k_reg);

    always_comb
    begin
        case (cfg.fb_format)
            FMT_8BPP:
            begin
                xs        = XS_W'(px_x);
                size_next = SIZE_BYTE;
                data_next = {24'd0, color[7:0]};
            end
            FMT_RGB565:
            begin
                xs        = XS_W'(px_x) << 1;
                size_next = SIZE_HALF;
                data_next = {16'd0, to_rgb565(color)};
            end
            FMT_32BPP:
            begin
                xs        = XS_W'(px_x) << 2;
                size_next = SIZE_WORD;
                data_next = color;
            end
            default:
            begin
                xs        = '0;
                size_next = SIZE_BYTE;
                data_next = '0;
            end
        endcase
    end

    always_comb
    begin
        addr_next = base_reg + ADDR_BITS'(xs);
        last_next = k_last;
        done_next = k_last && ctl_reg.done;
        if (ctl_reg.err)
        begin
            addr_next = '0;
            last_next = 1'b1;
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvalid_reg <= 1'b0;
            k_reg      <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (desc_push)
            begin
                dvalid_reg <= 1'b1;
                k_reg      <= '0;
            end
            else if (out_load && k_last)
            begin
                dvalid_reg <= 1'b0;
            end
            else if (out_load)
            begin
                k_reg <= k_reg + 3'd1;
            end

            if (out_load)
                ovalid_reg <= 1'b1;
            else if (m_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_push)
        begin
            ctl_reg  <= desc_ctl;
            x_reg    <= desc_x;
            base_reg <= desc_row_base;
        end
        if (out_load)
        begin
            addr_reg <= addr_next;
            data_reg <= ctl_reg.err ? 32'd0 : data_next;
            size_reg <= ctl_reg.err ? SIZE_BYTE : size_next;
            last_reg <= last_next;
            done_reg <= done_next;
            err_reg  <= ctl_reg.err;
        end
    end

    assign m_tvalid      = ovalid_reg;
    assign pixel_address = addr_reg;
    assign pixel_data    = data_reg;
    assign pixel_size    = size_reg;
    assign last_of_byte  = last_reg;
    assign glyph_done    = done_reg;
    assign format_error  = err_reg;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the glyph bitmap expander: source bytes are streamed
// in, every pixel write is predicted by a bench-side glyph walker and compared
// field by field in arrival order, under random stalls on both streams.
// ----------------------------------------------------------------------------
module tb;

    import gbe_pkg::*;

    localparam int ADDR_W        = ADDR_BITS_DEF;
    localparam int PIX_W         = ((ADDR_BITS_DEF + 34 + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int MAX_PRINTED   = 60;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [31:0]       data;
        logic [1:0]        size;
        logic              last;
        logic              done;
        logic              err;
    } pixel_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;    // src_byte
    logic                   m_tvalid;
    logic                   m_tready;
    logic [PIX_W-1:0]       m_tdata;    // pixel_address, pixel_data, pixel_size
    logic                   m_tlast;    // last_of_byte
    logic [1:0]             m_tuser;    // glyph_done, format_error

    // bench copy of the glyph walker
    cfg_t   model_cfg;
    int     row_cnt;
    int     col_cnt;
    int     byte_cnt;
    bit     glyph_finished;
    pixel_t pending_px[$];

    bit     tx_idle;
    bit     rx_idle;
    int     rx_hold;
    int     live_items;
    int     mismatch_count;
    int     cycle_count;

    glyph_bitmap_expander DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] seen);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t ns  %s: expected 0x%0h, got 0x%0h", $time, what, want, seen);
    endtask

    function automatic void restart_glyph();
        row_cnt        = 0;
        col_cnt        = 0;
        byte_cnt       = 0;
        glyph_finished = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [31:0] val);
        case (idx)
            REG_FB_FORMAT:   model_cfg.fb_format         = val[1:0];
            REG_LINE_BYTES:  model_cfg.line_bytes        = val[15:0];
            REG_FG_COLOR:    model_cfg.fg_color          = val;
            REG_BG_COLOR:    model_cfg.bg_color          = val;
            REG_DEPTH_EIGHT: model_cfg.glyph_depth_eight = val[0];
            REG_ORIGIN:      model_cfg.glyph_origin      = val[27:0];
            REG_EXTENT:      model_cfg.glyph_extent      = val[27:0];
            default:         model_cfg.glyph_pitch       = val[10:0];
        endcase
        restart_glyph();
    endfunction

    // predicts the pixel writes of one accepted source byte
    function automatic void expand_byte(input logic [7:0] src);
        int          w;
        int          h;
        int          n;
        int          k;
        int          sh;
        int          pitch;
        bit          row_end;
        logic        lit;
        logic [13:0] ox;
        logic [13:0] oy;
        logic [13:0] colv;
        logic [13:0] rowv;
        logic [13:0] x;
        logic [13:0] y;
        logic [1:0]  sz;
        logic [31:0] c;
        logic [63:0] a;
        pixel_t      px;
        w  = model_cfg.glyph_extent[13:0];
        h  = model_cfg.glyph_extent[27:14];
        ox = model_cfg.glyph_origin[13:0];
        oy = model_cfg.glyph_origin[27:14];
        if (glyph_finished)
            return;
        if (row_cnt >= h)
        begin
            glyph_finished = 1'b1;
            return;
        end
        n = 0;
        if (col_cnt < w)
            n = model_cfg.glyph_depth_eight ? 1 : ((w - col_cnt < 8) ? w - col_cnt : 8);
        // unsupported format aborts the glyph with a single error transaction
        if (n > 0 && model_cfg.fb_format == FMT_BAD)
        begin
            px      = '0;
            px.last = 1'b1;
            px.err  = 1'b1;
            pending_px.push_back(px);
            glyph_finished = 1'b1;
            return;
        end
        case (model_cfg.fb_format)
            FMT_RGB565:
            begin
                sz = SIZE_HALF;
                sh = 1;
            end
            FMT_32BPP:
            begin
                sz = SIZE_WORD;
                sh = 2;
            end
            default:
            begin
                sz = SIZE_BYTE;
                sh = 0;
            end
        endcase
        for (k = 0; k < n; k++)
        begin
            lit = model_cfg.glyph_depth_eight ? (src != 8'h00) : src[7-k];
            c   = lit ? model_cfg.fg_color : model_cfg.bg_color;
            case (sz)
                SIZE_BYTE: px.data = {24'h0, c[7:0]};
                SIZE_HALF: px.data = {16'h0, c[23:19], c[15:10], c[7:3]};
                default:   px.data = c;
            endcase
            colv = col_cnt + k;
            rowv = row_cnt;
            x    = ox + colv;
            y    = oy + rowv;
            a    = {50'h0, y} * {48'h0, model_cfg.line_bytes} + ({50'h0, x} << sh);
            px.addr = a[ADDR_W-1:0];
            px.size = sz;
            px.last = (k + 1 == n);
            px.done = (col_cnt + k + 1 == w) && (row_cnt + 1 == h);
            px.err  = 1'b0;
            pending_px.push_back(px);
        end
        col_cnt += n;
        if (model_cfg.glyph_depth_eight)
            row_end = (col_cnt >= w);
        else
        begin
            pitch = (model_cfg.glyph_pitch == 0) ? 1 : model_cfg.glyph_pitch;
            byte_cnt++;
            row_end = (byte_cnt >= pitch);
        end
        if (row_end)
        begin
            col_cnt  = 0;
            byte_cnt = 0;
            row_cnt++;
            if (row_cnt >= h)
                glyph_finished = 1'b1;
        end
    endfunction

    function automatic cfg_t make_setup(input logic [1:0] fmt, input logic [15:0] lb,
                                        input logic [31:0] fg, input logic [31:0] bg,
                                        input logic d8, input logic [13:0] ox,
                                        input logic [13:0] oy, input logic [13:0] w,
                                        input logic [13:0] h, input logic [10:0] pitch);
        cfg_t c;
        c.fb_format         = fmt;
        c.line_bytes        = lb;
        c.fg_color          = fg;
        c.bg_color          = bg;
        c.glyph_depth_eight = d8;
        c.glyph_origin      = {oy, ox};
        c.glyph_extent      = {h, w};
        c.glyph_pitch       = pitch;
        return c;
    endfunction

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        apply_reg(idx, val);
    endtask

    // writes every register; only called while the block is idle
    task automatic load_glyph_setup(input cfg_t c);
        put_reg(REG_FB_FORMAT,   {30'h0, c.fb_format});
        put_reg(REG_LINE_BYTES,  {16'h0, c.line_bytes});
        put_reg(REG_FG_COLOR,    c.fg_color);
        put_reg(REG_BG_COLOR,    c.bg_color);
        put_reg(REG_DEPTH_EIGHT, {31'h0, c.glyph_depth_eight});
        put_reg(REG_ORIGIN,      {4'h0, c.glyph_origin});
        put_reg(REG_EXTENT,      {4'h0, c.glyph_extent});
        put_reg(REG_PITCH,       {21'h0, c.glyph_pitch});
        cfg_we <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_idle ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        // inputs are settled at the falling edge, the transaction lands on the next rise
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        if (!glyph_finished)
            live_items++;
        expand_byte(b);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge clk);
    endtask

    // bytes that give no write may still be in flight after the last transaction
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return $urandom;
    endfunction

    initial
    begin : pixel_sink
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            stall = rx_idle ? $urandom_range(0, 18) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(negedge clk); while (!m_tvalid && rx_hold == 0);
            @(posedge clk);
        end
    end

    always @(negedge clk)
    begin : pixel_check
        pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_px.size() == 0)
                report_mismatch("unexpected write, address", 32'h0, m_tdata[ADDR_W-1:0]);
            else
            begin
                want = pending_px.pop_front();
                if (m_tdata[ADDR_W-1:0] !== want.addr)
                    report_mismatch("pixel_address", want.addr, m_tdata[ADDR_W-1:0]);
                if (m_tdata[ADDR_W +: 32] !== want.data)
                    report_mismatch("pixel_data", want.data, m_tdata[ADDR_W +: 32]);
                if (m_tdata[ADDR_W+32 +: 2] !== want.size)
                    report_mismatch("pixel_size", want.size, m_tdata[ADDR_W+32 +: 2]);
                if (m_tlast !== want.last)
                    report_mismatch("last_of_byte", want.last, m_tlast);
                if (m_tuser[0] !== want.done)
                    report_mismatch("glyph_done", want.done, m_tuser[0]);
                if (m_tuser[1] !== want.err)
                    report_mismatch("format_error", want.err, m_tuser[1]);
            end
        end
    end

    // reset values: 32bpp and an empty extent, so a byte only finishes the glyph
    task automatic test_reset_state();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_byte(8'hC3);
        settle();
    endtask

    // 1-bit rows with a pitch wider than the glyph: the third byte of a row is unused
    task automatic test_packed_rows();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        load_glyph_setup(make_setup(FMT_32BPP, 16'd1000, 32'hFFFF_FFFF, 32'h0, 1'b0,
                                    14'd3, 14'd5, 14'd10, 14'd2, 11'd3));
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h5A);
        send_byte(8'hA5);
        send_byte(8'h80);
        send_byte(8'h3C);
        settle();
    endtask

    // 8-bit source into RGB565, zero line pitch; the extra byte is ignored
    task automatic test_byte_pixels();
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        load_glyph_setup(make_setup(FMT_RGB565, 16'd0, 32'h00F8_FCF8, 32'h00AB_CDEF, 1'b1,
                                    14'd0, 14'd0, 14'd3, 14'd1, 11'd0));
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'h7E);
        settle();
    endtask

    // pitch smaller than the width ends each row early; a pitch of zero acts as one
    task automatic test_narrow_pitch();
        tx_idle = 1'b1;
        rx_idle = 1'b0;
        load_glyph_setup(make_setup(FMT_8BPP, 16'd320, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0,
                                    14'd100, 14'd7, 14'd12, 14'd2, 11'd1));
        send_byte(8'hF0);
        send_byte(8'h0F);
        settle();
        load_glyph_setup(make_setup(FMT_8BPP, 16'd64, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0,
                                    14'd0, 14'd0, 14'd8, 14'd1, 11'd0));
        send_byte(8'h5A);
        settle();
    endtask

    // unsupported format: bytes with no pixels just advance, otherwise one error
    task automatic test_bad_format();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        load_glyph_setup(make_setup(FMT_BAD, 16'd50, 32'h00FF_0000, 32'h0000_00FF, 1'b0,
                                    14'd0, 14'd0, 14'd0, 14'd2, 11'd1));
        send_byte(8'h11);
        send_byte(8'h22);
        settle();
        load_glyph_setup(make_setup(FMT_BAD, 16'd50, 32'h00FF_0000, 32'h0000_00FF, 1'b0,
                                    14'd1, 14'd1, 14'd4, 14'd2, 11'd1));
        send_byte(8'h9C);
        send_byte(8'h9C);
        settle();
    endtask

    // origin at the top of both coordinate ranges with the widest line
    task automatic test_coord_wrap();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        load_glyph_setup(make_setup(FMT_32BPP, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 1'b1,
                                    14'h3FFF, 14'h3FFF, 14'd2, 14'd2, 11'd0));
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h00);
        settle();
    endtask

    // zero height finishes at once; zero width in 8-bit mode ends a row per byte
    task automatic test_empty_glyph();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        load_glyph_setup(make_setup(FMT_RGB565, 16'd8, 32'h00FF_FFFF, 32'h0, 1'b0,
                                    14'd0, 14'd0, 14'd5, 14'd0, 11'd1));
        send_byte(8'hFF);
        settle();
        load_glyph_setup(make_setup(FMT_RGB565, 16'd8, 32'h00FF_FFFF, 32'h0, 1'b1,
                                    14'd0, 14'd0, 14'd0, 14'd2, 11'd0));
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        settle();
    endtask

    // sink holds off while bytes keep coming, so the block backs up into its input
    task automatic test_output_stall();
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        load_glyph_setup(make_setup(FMT_32BPP, $urandom, $urandom, $urandom, 1'b0,
                                    $urandom, $urandom, 14'd16, 14'd4, 11'd2));
        rx_hold = 300;
        repeat (8) send_byte($urandom);
        settle();
    endtask

    // sender stops mid-glyph until every pending write has gone out
    task automatic test_drain_pause();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        load_glyph_setup(make_setup(FMT_RGB565, $urandom, $urandom, $urandom, 1'b1,
                                    $urandom, $urandom, 14'd6, 14'd2, 11'd0));
        repeat (6) send_byte(pick_byte());
        drain();
        repeat (6) send_byte(pick_byte());
        settle();
    endtask

    // largest extent and pitch; only a few bytes of the first row are sent
    task automatic test_large_glyph();
        tx_idle = 1'b1;
        rx_idle = 1'b0;
        load_glyph_setup(make_setup(FMT_32BPP, $urandom, $urandom, $urandom, 1'b0,
                                    $urandom, $urandom, 14'h3FFF, 14'h3FFF, 11'h7FF));
        repeat (6) send_byte($urandom);
        settle();
    endtask

    task automatic test_random_glyphs();
        cfg_t c;
        int   w;
        int   h;
        int   p;
        int   len;
        int   mode;
        int   goal;
        goal = live_items + 50;
        while (live_items < goal)
        begin
            w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
            h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
            p = (w + 7) / 8 + $urandom_range(0, 1);
            if ($urandom_range(0, 7) == 0)
                p = $urandom_range(0, 3);
            c = make_setup(($urandom_range(0, 7) == 0) ? FMT_BAD : $urandom_range(0, 2),
                           $urandom, $urandom, $urandom, $urandom_range(0, 1),
                           $urandom, $urandom, w, h, p);
            mode    = $urandom_range(0, 3);
            tx_idle = mode[0];
            rx_idle = mode[1];
            load_glyph_setup(c);
            if (c.glyph_depth_eight)
                len = ((w == 0) ? 1 : w) * h;
            else
                len = ((p == 0) ? 1 : p) * h;
            len += $urandom_range(0, 2);
            repeat (len) send_byte(pick_byte());
            settle();
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= REG_FB_FORMAT;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        tx_idle        = 1'b0;
        rx_idle        = 1'b0;
        rx_hold        = 0;
        live_items     = 0;
        mismatch_count = 0;
        model_cfg           = '0;
        model_cfg.fb_format = FMT_32BPP;
        restart_glyph();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_state();
        test_packed_rows();
        test_byte_pixels();
        test_narrow_pitch();
        test_bad_format();
        test_coord_wrap();
        test_empty_glyph();
        test_output_stall();
        test_drain_pause();
        test_large_glyph();
        test_random_glyphs();

        settle();
        if (pending_px.size() != 0)
            report_mismatch("writes never seen", 32'h0, pending_px.size());
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== glyph_bitmap_expander.f =====
design/gbe_pkg.sv
design/gbe_cfg.sv
design/gbe_walker.sv
design/gbe_emitter.sv
design/glyph_bitmap_expander.sv
sim/tb.sv
